// ----- rtl/lrukv_pkg.sv -----
package lrukv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 5;
    localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 31;
    localparam int S_DATA_W    = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((VAL_W + 7) / 8) * 8;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } opcode_t;

    typedef struct packed {
        logic load_item;
        logic match;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// ----- rtl/lru_key_value_cache_top.sv -----
// Fully associative key-value cache with least-recently-used replacement.
// Each input item is a get (tuser = 0) or a put (tuser = 1) on a 32-bit key;
// each gives exactly one result item whose tuser says whether the key was
// present before the item and whose tdata carries the stored value on a get
// hit, the written value on a put, or zero on a get miss. An item is first
// accepted and latched; then the parallel key compare and victim search run
// and issue the value memory read; then ranks, keys and the value memory are
// updated and the result is loaded, or, while the output register is still
// full and m_axis_tready is low, loaded once it frees. The next item is
// accepted in the cycle after the result is loaded, so the block takes no new
// item before it is through with the last one. cfg_wdata sets how many
// entries may be held before the least recent one is replaced; write it
// only while idle.
module lru_key_value_cache_top
    import lrukv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic                s_axis_tuser,   // opcode
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // lookup_key, write_value, zero pad
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic                m_axis_tuser,   // found
    output logic [M_DATA_W-1:0] m_axis_tdata    // read_value, zero pad
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    lrukv_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    lrukv_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .sts           (sts)
    );

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !sts.out_busy)
        else $error("result loaded over one not yet taken");

    a_update_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> $past(cmd.match))
        else $error("state update without a preceding key compare");

endmodule

// ----- rtl/lrukv_ram.sv -----
module lrukv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lrukv_ctrl.sv -----
module lrukv_ctrl
    import lrukv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MATCH  = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_WAIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.load_item = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.match  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/lrukv_dp.sv -----
module lrukv_dp
    import lrukv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_axis_tuser,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic                m_axis_tuser,
    output logic [M_DATA_W-1:0] m_axis_tdata,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          sts
);

    logic [CFG_W-1:0]  cap_reg;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;

    logic [KEY_W-1:0]  keys_reg  [MAX_ENTRIES];
    logic [SLOT_W-1:0] rank_reg  [MAX_ENTRIES];
    logic              valid_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]  occ_reg;

    logic              hit_reg;
    logic              fresh_reg;
    logic [SLOT_W-1:0] tgt_reg;
    logic [SLOT_W-1:0] tgt_rank_reg;

    logic              out_valid_reg;
    logic              out_found_reg;
    logic [VAL_W-1:0]  out_value_reg;

    logic              hit_any;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] vic_idx;
    logic [SLOT_W-1:0] free_idx;
    logic [CNT_W-1:0]  occ_m1;
    logic [CMP_W-1:0]  eff_cap;
    logic              evict;
    logic [SLOT_W-1:0] tgt_slot;
    logic [VAL_W-1:0]  ram_rdata;
    logic              ram_we;
    logic [VAL_W-1:0]  res_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg  <= s_axis_tuser;
            key_reg <= s_axis_tdata[KEY_W-1:0];
            val_reg <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    // Capacity zero acts as one; anything above the table size saturates.
    always_comb begin
        priority if (cap_reg == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign occ_m1 = occ_reg - CNT_W'(1);
    assign evict  = CMP_W'(occ_reg) >= eff_cap;

    // Valid ranks form a permutation of 0 .. occupancy-1, so the least recent
    // entry is the one whose rank equals occupancy minus one.
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        vic_idx  = '0;
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && keys_reg[i] == key_reg) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == occ_m1[SLOT_W-1:0]) begin
                vic_idx = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        priority if (hit_any) begin
            tgt_slot = hit_idx;
        end else if (evict) begin
            tgt_slot = vic_idx;
        end else begin
            tgt_slot = free_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.match) begin
            hit_reg      <= hit_any;
            fresh_reg    <= !hit_any && !evict;
            tgt_reg      <= tgt_slot;
            tgt_rank_reg <= rank_reg[tgt_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
            occ_reg <= '0;
        end else if (cmd.update && (hit_reg || op_reg == OP_PUT)) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (SLOT_W'(i) == tgt_reg) begin
                    valid_reg[i] <= 1'b1;
                    rank_reg[i]  <= '0;
                end else if (valid_reg[i] && (fresh_reg || rank_reg[i] < tgt_rank_reg)) begin
                    rank_reg[i] <= rank_reg[i] + SLOT_W'(1);
                end
            end
            if (fresh_reg) begin
                occ_reg <= occ_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && op_reg == OP_PUT && !hit_reg) begin
            keys_reg[tgt_reg] <= key_reg;
        end
    end

    assign ram_we = cmd.update && op_reg == OP_PUT;

    lrukv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_values (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tgt_reg),
        .wdata (val_reg),
        .re    (cmd.match),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        priority if (op_reg == OP_PUT) begin
            res_value = val_reg;
        end else if (hit_reg) begin
            res_value = ram_rdata;
        end else begin
            res_value = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_found_reg <= hit_reg;
            out_value_reg <= res_value;
        end
    end

    assign sts.out_busy  = out_valid_reg && !m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = M_DATA_W'(out_value_reg);

endmodule

// ----- tb/tb_lru_key_value_cache_top.sv -----
module tb_lru_key_value_cache_top;
    import lrukv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        opcode_t          op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cache_req_t;

    typedef struct {
        logic             found;
        logic [VAL_W-1:0] value;
    } cache_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic                s_axis_tuser  = 1'b0;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic                m_axis_tuser;
    logic [M_DATA_W-1:0] m_axis_tdata;

    lru_key_value_cache_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    cache_req_t    pending_items [$];
    cache_result_t expected_results [$];
    cache_result_t oldest_result;

    // Shadow copy of the cache contents and recency order.
    logic [KEY_W-1:0] shadow_key   [MAX_ENTRIES];
    logic [VAL_W-1:0] shadow_value [MAX_ENTRIES];
    bit               shadow_used  [MAX_ENTRIES];
    int               shadow_rank  [MAX_ENTRIES];
    int               shadow_count = 0;
    logic [CFG_W-1:0] capacity_setting = CAP_RESET;

    int mismatches    = 0;
    int get_count     = 0;
    int put_count     = 0;
    int hit_count     = 0;
    int evict_count   = 0;
    int results_seen  = 0;
    int setting_count = 0;
    int cycle_count   = 0;

    int          burst_left    = 1;
    int          gap_left      = 0;
    int          stall_mode    = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;

    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_used[i]  = 1'b0;
            shadow_rank[i]  = 0;
        end
    end

    // Entries that were more recent than this slot age by one.
    function automatic void make_recent(int slot);
        int r;
        r = shadow_rank[slot];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (shadow_used[i] && i != slot && shadow_rank[i] < r)
                shadow_rank[i]++;
        end
        shadow_rank[slot] = 0;
    endfunction

    function automatic cache_result_t predict_access(cache_req_t req);
        cache_result_t res;
        int hit;
        int slot;
        int oldest;
        int cap;
        hit = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit < 0 && shadow_used[i] && shadow_key[i] == req.key)
                hit = i;
        end
        res.found = (hit >= 0);
        res.value = '0;
        if (hit >= 0)
            hit_count++;
        if (req.op == OP_GET) begin
            get_count++;
            if (hit >= 0) begin
                res.value = shadow_value[hit];
                make_recent(hit);
            end
        end else begin
            put_count++;
            res.value = req.value;
            if (hit >= 0) begin
                shadow_value[hit] = req.value;
                make_recent(hit);
            end else begin
                cap = (capacity_setting == 0) ? 1 :
                      (capacity_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_setting);
                slot = -1;
                if (shadow_count >= cap) begin
                    // Replace the least recent entry; occupancy is unchanged.
                    oldest = 0;
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (shadow_used[i] && (slot < 0 || shadow_rank[i] > oldest)) begin
                            slot   = i;
                            oldest = shadow_rank[i];
                        end
                    end
                    if (slot >= 0) begin
                        evict_count++;
                        shadow_key[slot]   = req.key;
                        shadow_value[slot] = req.value;
                        make_recent(slot);
                    end
                end
                if (slot < 0) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (slot < 0 && !shadow_used[i])
                            slot = i;
                    end
                    if (slot >= 0) begin
                        for (int i = 0; i < MAX_ENTRIES; i++) begin
                            if (shadow_used[i])
                                shadow_rank[i]++;
                        end
                        shadow_key[slot]   = req.key;
                        shadow_value[slot] = req.value;
                        shadow_used[slot]  = 1'b1;
                        shadow_rank[slot]  = 0;
                        shadow_count++;
                    end
                end
            end
        end
        return res;
    endfunction

    // Sender: bursts of items separated by random gaps; valid holds until taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_access(pending_items.pop_front()));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 || pending_items.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_items[0].op;
                    s_axis_tdata  <= S_DATA_W'({pending_items[0].value, pending_items[0].key});
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: checks each result against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected: found %0b, value %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_axis_tuser !== oldest_result.found) begin
                        mismatches++;
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, oldest_result.found, m_axis_tuser);
                    end
                    if (m_axis_tdata !== M_DATA_W'(oldest_result.value)) begin
                        mismatches++;
                        $display("%0t: read_value mismatch: expected %0h, actual %0h",
                                 $time, M_DATA_W'(oldest_result.value), m_axis_tdata);
                    end
                end
            end
            if (hold_left > 0)
                m_axis_tready <= 1'b0;
            else if (stall_mode == 1)
                m_axis_tready <= stall_pattern[cycle_count % 16];
            else if (stall_mode == 2)
                m_axis_tready <= ($urandom_range(0, 2) != 0);
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_left   <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_item(opcode_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        cache_req_t req;
        req.op    = op;
        req.key   = key;
        req.value = value;
        pending_items.push_back(req);
    endtask

    // Mostly keys from a small working set so that hits, updates and
    // evictions dominate; the rest are fresh keys and key extremes.
    task automatic queue_random_items(int count, int pool_size);
        logic [KEY_W-1:0] pool [$];
        cache_req_t req;
        int pick;
        repeat (pool_size) pool.push_back($urandom());
        repeat (count) begin
            req.op = opcode_t'($urandom_range(0, 1));
            pick = $urandom_range(0, 19);
            if (pick < 17)
                req.key = pool[$urandom_range(0, pool_size - 1)];
            else if (pick == 17)
                req.key = ($urandom_range(0, 1) != 0) ? '1 : '0;
            else
                req.key = $urandom();
            pick = $urandom_range(0, 15);
            req.value = (pick == 0) ? '0 : (pick == 1) ? '1 : VAL_W'($urandom());
            pending_items.push_back(req);
        end
    endtask

    task automatic wait_until_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [CFG_W-1:0] cap);
        wait_until_drained();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        capacity_setting = cap;
        @(posedge aclk);
        cfg_we <= 1'b0;
        stall_mode    = setting_count % 3;
        stall_pattern = 16'($urandom()) | 16'h0101;
        setting_count++;
        @(negedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        set_capacity(5'd16);
        queue_item(OP_GET, 32'h0000_0000, 31'h7FFF_FFFF);
        queue_item(OP_PUT, 32'h0000_0000, 31'h0000_0000);
        queue_item(OP_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        queue_item(OP_GET, 32'h0000_0000, 31'h5555_5555);
        queue_item(OP_GET, 32'hFFFF_FFFF, 31'h0000_0000);
        queue_item(OP_PUT, 32'h0000_0000, 31'h7FFF_FFFF);
        queue_item(OP_GET, 32'h0000_0000, 31'h0000_0000);
        queue_item(OP_GET, 32'hA5A5_5A5A, 31'h2AAA_AAAA);
        queue_item(OP_PUT, 32'h8000_0001, 31'h4000_0001);

        // A capacity of zero behaves as a single entry.
        set_capacity(5'd0);
        queue_item(OP_PUT, 32'h1234_5678, 31'h0000_1111);
        queue_item(OP_PUT, 32'h8765_4321, 31'h0000_2222);
        queue_item(OP_GET, 32'h1234_5678, 31'h0000_0000);
        queue_item(OP_GET, 32'h8765_4321, 31'h0000_0000);
        queue_item(OP_PUT, 32'h8765_4321, 31'h0000_3333);
        queue_item(OP_GET, 32'h0000_0000, 31'h0000_0000);
        queue_random_items(100, 4);

        // Above the entry count the capacity saturates.
        set_capacity(5'd31);
        queue_random_items(300, 24);
        hold_requests++;

        // The table is full here, so these run with occupancy above capacity.
        set_capacity(5'd2);
        queue_random_items(200, 6);

        set_capacity(5'd1);
        queue_random_items(150, 3);

        set_capacity(5'd17);
        queue_random_items(200, 20);

        set_capacity(5'd8);
        queue_random_items(300, 12);
        hold_requests++;

        set_capacity(CFG_W'($urandom_range(1, 31)));
        queue_random_items(400, $urandom_range(4, 24));

        wait_until_drained();
        repeat (12) @(posedge aclk);

        $display("Ran %0d items (%0d gets, %0d puts) under %0d capacity settings,",
                 get_count + put_count, get_count, put_count, setting_count);
        $display("with %0d key hits, %0d replacements and %0d results checked.",
                 hit_count, evict_count, results_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
